[rtl/grow_live_die_envelope_assert.svh]
// Assertion macros for the envelope generator.
// Used by the top level; no other dependencies.
`ifndef GROW_LIVE_DIE_ENVELOPE_ASSERT_SVH
`define GROW_LIVE_DIE_ENVELOPE_ASSERT_SVH
`ifndef SYNTHESIS
`define GLD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define GLD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define GLD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define GLD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/gld_pkg.sv]
// Shared types, codes and the half-cosine weight table for the envelope generator.
// No dependencies.
package gld_pkg;

    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 16;
    localparam int COS_DEPTH  = 256;
    localparam int HALF_DEPTH = COS_DEPTH / 2;
    localparam int RATIO_W    = 17;
    localparam int FAST_FALL  = 10;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_PAUSE = 3'd1;
    localparam logic [2:0] CMD_PLAY  = 3'd2;
    localparam logic [2:0] CMD_SLEEP = 3'd3;
    localparam logic [2:0] CMD_DIE   = 3'd4;

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_GROW  = 3'd1;
    localparam logic [2:0] PH_HOLD  = 3'd2;
    localparam logic [2:0] PH_FALL  = 3'd3;
    localparam logic [2:0] PH_DEAD  = 3'd4;
    localparam logic [2:0] PH_SLEEP = 3'd5;
    localparam logic [2:0] PH_STOP  = 3'd6;

    localparam logic [2:0] REG_GROW  = 3'd0;
    localparam logic [2:0] REG_FALL  = 3'd1;
    localparam logic [2:0] REG_HOLD  = 3'd2;
    localparam logic [2:0] REG_BPER  = 3'd3;
    localparam logic [2:0] REG_BDEP  = 3'd4;
    localparam logic [2:0] REG_START = 3'd5;
    localparam logic [2:0] REG_REST  = 3'd6;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] elapsed;
    } in_t;

    typedef struct packed {
        logic [15:0] level;
        logic [2:0]  phase;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               start;
        logic [RATIO_W-1:0] ratio;
        logic [LEVEL_W-1:0] amp;
        logic               rising;
    } mix_req_t;

    typedef logic [15:0] hw_tab_t [0:HALF_DEPTH];

    // (1 - cos(pi * j / depth)) / 2 in Q16 from a Q30 Taylor series.
    function automatic logic [15:0] half_weight(input int j);
        logic [63:0] th;
        logic [63:0] t;
        logic [63:0] p;
        th = (64'd3373259426 * 64'(j)) / COS_DEPTH;
        t  = (th * th) >> 30;
        p  = 64'd296;
        p  = 64'd26630 - ((t * p) >> 30);
        p  = 64'd1491308 - ((t * p) >> 30);
        p  = 64'd44739243 - ((t * p) >> 30);
        p  = 64'd536870912 - ((t * p) >> 30);
        p  = (t * p) >> 30;
        p  = (p + 64'd16384) >> 15;
        return p[15:0];
    endfunction

    function automatic hw_tab_t build_half_weight();
        hw_tab_t tab;
        for (int j = 0; j <= HALF_DEPTH; j++) begin
            tab[j] = half_weight(j);
        end
        return tab;
    endfunction

    localparam hw_tab_t HALF_WEIGHT = build_half_weight();

    function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

[rtl/grow_live_die_envelope.sv]
// Envelope generator top level: sequencer, envelope state and output register.
// A tick computes up to two ratios (beat, then rise or fall) on the shared 16-step divider,
// each followed by a cosine interpolation; a ratio of one or more is clamped to one.
// Input is ready again with the result.
// Reset (aresetn low, synchronous) restores the register defaults and the waiting phase.
module grow_live_die_envelope (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gld_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gld_pkg::out_t m_data,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wdata
);
    import gld_pkg::*;
    `include "grow_live_die_envelope_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_BEAT, S_BEAT_DIV, S_BEAT_MIX, S_PHASE, S_MAIN_DIV, S_MAIN_MIX, S_DONE
    } state_t;

    state_t state_reg;

    logic [TIME_W-1:0]  grow_dur_reg, fall_dur_reg, hold_dur_reg, beat_per_reg, start_dly_reg;
    logic [14:0]        beat_depth_reg;
    logic [LEVEL_W-1:0] rest_reg;

    logic [2:0]         phase_reg, saved_reg;
    logic [LEVEL_W-1:0] level_reg, offset_reg, target_reg, amp_reg;
    logic [TIME_W-1:0]  wait_tmr_reg, hold_tmr_reg, rise_tmr_reg, fall_tmr_reg, beat_tmr_reg;
    logic               rising_reg, fast_reg, cancel_reg, dir_reg;
    logic [15:0]        dt_reg;

    logic               m_valid_reg;
    out_t               m_data_reg;

    div_req_t           div_req;
    mix_req_t           mix_req;
    logic               div_done, mix_done;
    logic [RATIO_W-1:0] div_ratio;
    logic [LEVEL_W-1:0] mix_result;

    logic [TIME_W-1:0]  beat_sum, rise_sum, hold_sum, fall_sum, eff_hold;
    logic [19:0]        fall_step;
    logic [LEVEL_W:0]   peak_sum;
    logic [LEVEL_W-1:0] peak;
    logic               beat_wrap, in_beat_phase;

    always_comb begin
        beat_sum      = time_add(beat_tmr_reg, TIME_W'(dt_reg));
        rise_sum      = time_add(rise_tmr_reg, TIME_W'(dt_reg));
        hold_sum      = time_add(hold_tmr_reg, TIME_W'(dt_reg));
        fall_step     = fast_reg ? 20'(dt_reg) * 20'(FAST_FALL) : 20'(dt_reg);
        fall_sum      = time_add(fall_tmr_reg, TIME_W'(fall_step));
        eff_hold      = cancel_reg ? '0 : hold_dur_reg;
        peak_sum      = {1'b0, target_reg} + {1'b0, offset_reg};
        peak          = peak_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : peak_sum[LEVEL_W-1:0];
        beat_wrap     = beat_sum >= beat_per_reg;
        in_beat_phase = phase_reg == PH_HOLD || phase_reg == PH_FALL;

        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        if (state_reg == S_BEAT) begin
            div_req.start = beat_per_reg != '0 && in_beat_phase;
            div_req.num   = beat_wrap ? '0 : beat_sum;
            div_req.den   = beat_per_reg;
        end else if (state_reg == S_PHASE) begin
            div_req.start = phase_reg == PH_GROW || phase_reg == PH_FALL;
            div_req.num   = (phase_reg == PH_GROW) ? rise_sum : fall_sum;
            div_req.den   = (phase_reg == PH_GROW) ? grow_dur_reg : fall_dur_reg;
        end

        mix_req.start  = div_done && (state_reg == S_BEAT_DIV || state_reg == S_MAIN_DIV);
        mix_req.ratio  = div_ratio;
        mix_req.amp    = (state_reg == S_BEAT_DIV) ? LEVEL_W'(beat_depth_reg) : amp_reg;
        mix_req.rising = (state_reg == S_BEAT_DIV) ? rising_reg : dir_reg;
    end

    gld_ratio_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .ratio   (div_ratio)
    );

    gld_interp u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mix_req),
        .done    (mix_done),
        .result  (mix_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            grow_dur_reg   <= 32'd65536;
            fall_dur_reg   <= 32'd65536;
            hold_dur_reg   <= '0;
            beat_per_reg   <= '0;
            beat_depth_reg <= '0;
            start_dly_reg  <= '0;
            rest_reg       <= 16'd16384;
            phase_reg      <= PH_WAIT;
            saved_reg      <= PH_WAIT;
            level_reg      <= '0;
            wait_tmr_reg   <= '0;
            hold_tmr_reg   <= '0;
            rise_tmr_reg   <= '0;
            fall_tmr_reg   <= '0;
            beat_tmr_reg   <= '0;
            rising_reg     <= 1'b1;
            offset_reg     <= '0;
            target_reg     <= 16'd16384;
            fast_reg       <= 1'b0;
            cancel_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        dt_reg    <= s_data.elapsed;
                        state_reg <= S_DONE;
                        priority case (s_data.cmd)
                            CMD_TICK: state_reg <= S_BEAT;
                            CMD_PAUSE: begin
                                if (phase_reg != PH_STOP) begin
                                    saved_reg <= phase_reg;
                                    phase_reg <= PH_STOP;
                                end
                            end
                            CMD_PLAY: begin
                                if (phase_reg == PH_STOP) begin
                                    phase_reg <= saved_reg;
                                end else if (phase_reg == PH_SLEEP) begin
                                    phase_reg <= PH_HOLD;
                                end
                            end
                            CMD_SLEEP: begin
                                if (phase_reg != PH_GROW) begin
                                    phase_reg <= PH_SLEEP;
                                end
                            end
                            CMD_DIE: begin
                                if (in_beat_phase) begin
                                    fast_reg   <= 1'b1;
                                    cancel_reg <= 1'b1;
                                end else if (phase_reg == PH_GROW) begin
                                    fast_reg     <= 1'b1;
                                    target_reg   <= (level_reg > offset_reg) ?
                                                    level_reg - offset_reg : '0;
                                    rise_tmr_reg <= '0;
                                    phase_reg    <= PH_FALL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_BEAT: begin
                    state_reg <= S_PHASE;
                    if (beat_per_reg != '0) begin
                        if (!in_beat_phase) begin
                            rising_reg <= 1'b0;
                            offset_reg <= LEVEL_W'(beat_depth_reg);
                        end else begin
                            state_reg <= S_BEAT_DIV;
                            if (beat_wrap) begin
                                beat_tmr_reg <= '0;
                                rising_reg   <= !rising_reg;
                            end else begin
                                beat_tmr_reg <= beat_sum;
                            end
                        end
                    end
                end
                S_BEAT_DIV: begin
                    if (div_done) begin
                        state_reg <= S_BEAT_MIX;
                    end
                end
                S_BEAT_MIX: begin
                    if (mix_done) begin
                        offset_reg <= mix_result;
                        state_reg  <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    state_reg <= S_DONE;
                    amp_reg   <= peak;
                    unique case (phase_reg)
                        PH_WAIT: begin
                            if (wait_tmr_reg < start_dly_reg) begin
                                wait_tmr_reg <= time_add(wait_tmr_reg, TIME_W'(dt_reg));
                            end else begin
                                phase_reg <= PH_GROW;
                            end
                        end
                        PH_GROW: begin
                            dir_reg   <= 1'b1;
                            state_reg <= S_MAIN_DIV;
                            if (rise_sum >= grow_dur_reg) begin
                                rise_tmr_reg <= '0;
                                phase_reg    <= PH_HOLD;
                            end else begin
                                rise_tmr_reg <= rise_sum;
                            end
                        end
                        PH_HOLD: begin
                            if (eff_hold == '0 && fall_dur_reg != '0) begin
                                phase_reg <= PH_FALL;
                            end else begin
                                level_reg <= peak;
                                if (hold_sum >= eff_hold) begin
                                    hold_tmr_reg <= '0;
                                    if (fall_dur_reg != '0) begin
                                        phase_reg <= PH_FALL;
                                    end
                                end else begin
                                    hold_tmr_reg <= hold_sum;
                                end
                            end
                        end
                        PH_FALL: begin
                            dir_reg   <= 1'b0;
                            state_reg <= S_MAIN_DIV;
                            if (fall_sum >= fall_dur_reg) begin
                                fall_tmr_reg <= '0;
                                phase_reg    <= PH_DEAD;
                                target_reg   <= rest_reg;
                                fast_reg     <= 1'b0;
                                wait_tmr_reg <= '0;
                                beat_tmr_reg <= '0;
                            end else begin
                                fall_tmr_reg <= fall_sum;
                            end
                        end
                        PH_DEAD: phase_reg <= PH_GROW;
                        default: ;
                    endcase
                end
                S_MAIN_DIV: begin
                    if (div_done) begin
                        state_reg <= S_MAIN_MIX;
                    end
                end
                S_MAIN_MIX: begin
                    if (mix_done) begin
                        level_reg <= mix_result;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // The result waits here while the previous transfer is still pending.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_data_reg.level <= level_reg;
                        m_data_reg.phase <= phase_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (cfg_we) begin
                unique case (cfg_index)
                    REG_GROW:  grow_dur_reg <= cfg_wdata;
                    REG_FALL:  fall_dur_reg <= cfg_wdata;
                    REG_HOLD: begin
                        hold_dur_reg <= cfg_wdata;
                        cancel_reg   <= 1'b0;
                    end
                    REG_BPER:  beat_per_reg   <= cfg_wdata;
                    REG_BDEP:  beat_depth_reg <= cfg_wdata[14:0];
                    REG_START: start_dly_reg  <= cfg_wdata;
                    REG_REST: begin
                        rest_reg   <= cfg_wdata[15:0];
                        target_reg <= cfg_wdata[15:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `GLD_ASSERT_IMP(a_div_owner, aclk, aresetn, div_done, state_reg == S_BEAT_DIV || state_reg == S_MAIN_DIV, "divider finished with no owner")
    `GLD_ASSERT_IMP(a_mix_owner, aclk, aresetn, mix_done, state_reg == S_BEAT_MIX || state_reg == S_MAIN_MIX, "mixer finished with no owner")
    `GLD_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "second item taken while busy")
    `GLD_ASSERT_IMP(a_phase_code, aclk, aresetn, 1'b1, phase_reg <= PH_STOP, "phase register holds an unused code")
endmodule

[rtl/gld_ratio_div.sv]
// Shared restoring divider: ratio = (num << 16) / den in Q1.16, clamped to one.
// Depends on gld_pkg.
module gld_ratio_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gld_pkg::div_req_t         req,
    output logic                      done,
    output logic [gld_pkg::RATIO_W-1:0] ratio
);
    import gld_pkg::*;

    logic              busy_reg;
    logic [4:0]        cnt_reg;
    logic [TIME_W:0]   rem_reg;
    logic [TIME_W-1:0] den_reg;
    logic [15:0]       q_reg;
    logic              done_reg;
    logic [RATIO_W-1:0] ratio_reg;

    logic [TIME_W:0]   shifted;
    logic              take;
    logic [TIME_W:0]   rem_next;
    logic [15:0]       q_next;

    always_comb begin
        shifted  = {rem_reg[TIME_W-1:0], 1'b0};
        take     = shifted >= {1'b0, den_reg};
        rem_next = take ? shifted - {1'b0, den_reg} : shifted;
        q_next   = {q_reg[14:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (req.den == '0 || req.num >= req.den) begin
                    ratio_reg <= RATIO_W'(1 << 16);
                    done_reg  <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 5'd16;
                    rem_reg  <= {1'b0, req.num};
                    den_reg  <= req.den;
                    q_reg    <= '0;
                end
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    ratio_reg <= {1'b0, q_next};
                end
            end
        end
    end

    assign done  = done_reg;
    assign ratio = ratio_reg;
endmodule

[rtl/gld_interp.sv]
// Cosine interpolation unit: weight lookup, then one registered multiply.
// Depends on gld_pkg for the half-weight table.
module gld_interp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gld_pkg::mix_req_t         req,
    output logic                      done,
    output logic [gld_pkg::LEVEL_W-1:0] result
);
    import gld_pkg::*;

    logic [8:0]         idx;
    logic               low_half;
    logic [8:0]         mirror;
    logic [7:0]         j;
    logic [15:0]        hw;
    logic [16:0]        w;
    logic [16:0]        coef;

    logic               pend_reg;
    logic [16:0]        coef_reg;
    logic [LEVEL_W-1:0] amp_reg;
    logic               done_reg;
    logic [LEVEL_W-1:0] result_reg;

    logic [33:0]        prod;

    always_comb begin
        idx      = req.ratio[16:8];
        low_half = idx <= 9'(HALF_DEPTH);
        mirror   = 9'(COS_DEPTH) - idx;
        j        = low_half ? idx[7:0] : mirror[7:0];
        hw       = HALF_WEIGHT[j];
        w        = low_half ? {1'b0, hw} : 17'h10000 - {1'b0, hw};
        coef     = req.rising ? w : 17'h10000 - w;
        prod     = 34'(amp_reg) * 34'(coef_reg) + 34'd32768;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= pend_reg;
            pend_reg <= req.start;
            if (req.start) begin
                coef_reg <= coef;
                amp_reg  <= req.amp;
            end
            if (pend_reg) begin
                result_reg <= (prod[33:32] != 2'b00) ? {LEVEL_W{1'b1}} : prod[31:16];
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule
